// File: rtl/assert_macros.svh
// Assertion macros shared by the store queue RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SQF_ASSERT_IMP(lbl, clk, rstn, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
// Next-cycle implication outside reset.
`define SQF_ASSERT_NXT(lbl, clk, rstn, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`endif

// File: rtl/sqf_pkg.sv
// Package for the store queue: sizes, function codes, status codes, sequencer states.
// No dependencies.
package sqf_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int ROB_DEPTH   = 64;
  localparam int TAG_W       = $clog2(ROB_DEPTH);

  localparam logic [2:0] FN_PUSH   = 3'd0;
  localparam logic [2:0] FN_WADDR  = 3'd1;
  localparam logic [2:0] FN_WDATA  = 3'd2;
  localparam logic [2:0] FN_POP    = 3'd3;
  localparam logic [2:0] FN_COMMIT = 3'd4;
  localparam logic [2:0] FN_FLUSH  = 3'd5;
  localparam logic [2:0] FN_QUERY  = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
endpackage

// File: rtl/store_queue_forwarding_core.sv
// Store queue with store-to-load forwarding, top level.
// Depends on sqf_pkg and assert_macros.svh.
//
// Usage: requests arrive on the in_ valid/ready channel, one result per
// request leaves on the out_ valid/ready channel. Push, pop, flush and
// write requests that do not complete an entry are decoded directly.
// Write requests that complete an entry, commit and load query requests run
// a scan through the entry arrays, one entry per cycle, through a single
// shared address/tag compare unit, stepping through all QUEUE_DEPTH entries
// and then finishing in S_DONE. One request is in flight at a time, and
// the next is taken the cycle after the result leaves.
// The result sits in an output register; the block takes no new request
// until that result has been taken, so a stalled receiver simply holds
// the block. Reset clears the pointers, the known and committed flags and
// the control state; entry payload arrays are not cleared. There is no
// clearing pass after reset.
module store_queue_forwarding_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_slot,
  input  logic [sqf_pkg::TAG_W-1:0] in_rob_tag,
  input  logic [sqf_pkg::TAG_W-1:0] in_rob_head,
  input  logic [2:0]  in_byte_count,
  input  logic [31:0] in_mem_address,
  input  logic signed [31:0] in_store_data,
  input  logic [3:0]  in_tail_snapshot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_forward_valid,
  output logic signed [31:0] out_forward_value,
  output logic        out_may_dispatch,
  output logic        out_plan_valid,
  output logic [sqf_pkg::TAG_W-1:0] out_plan_store_tag,
  output logic [31:0] out_plan_address,
  output logic signed [31:0] out_plan_value,
  output logic        out_found_same,
  output logic [sqf_pkg::TAG_W-1:0] out_same_tag,
  output logic        out_found_unknown,
  output logic [sqf_pkg::TAG_W-1:0] out_unknown_tag
);
  import sqf_pkg::*;
  `include "assert_macros.svh"

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int TW = TAG_W;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Entry storage
  logic [TW-1:0] tag_mem [QUEUE_DEPTH];
  logic [31:0]   addr_mem [QUEUE_DEPTH];
  logic [31:0]   data_mem [QUEUE_DEPTH];
  logic [2:0]    bytes_mem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] addr_known_r, data_known_r, committed_r;
  logic [QW-1:0] head_r, tail_r;

  logic [1:0]    state_r;
  logic [2:0]    func_r;
  logic [QW-1:0] idx_r;     // written slot for plans
  logic [CW-1:0] cnt_r;     // scan step
  logic [TW-1:0] tag_r, rhead_r;
  logic [31:0]   addr_r;
  logic [TW-1:0] own_tag_r;
  logic [31:0]   own_data_r;

  // Scan accumulators
  logic fsame_r, funk_r, fwd_r, blocked_r, reached_r;
  logic [TW-1:0] stag_r, utag_r;
  logic [31:0] val_r;

  // Output register
  logic        out_valid_r;
  logic [1:0]  status_r;
  logic        plan_valid_r;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  wire acc = in_valid && in_ready;
  assign out_valid = out_valid_r;

  wire slot_ok = ({28'd0, in_slot} < 32'(QUEUE_DEPTH));
  wire [QW-1:0] slot_i = in_slot[QW-1:0];
  wire [QW-1:0] tail_inc = (tail_r == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  wire [QW-1:0] head_inc = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  wire full  = (tail_inc == head_r);
  wire empty = (head_r == tail_r);

  // Requests that need a pass through the compare unit
  wire scan_req = (in_func == FN_COMMIT) || (in_func == FN_QUERY) ||
                  (in_func == FN_WADDR && slot_ok && data_known_r[slot_i]) ||
                  (in_func == FN_WDATA && slot_ok && addr_known_r[slot_i]);

  function automatic logic [QW-1:0] qdist(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [QW:0] s;
    s = {1'b0, a} + (QW+1)'(QUEUE_DEPTH) - {1'b0, b};
    qdist = (s >= (QW+1)'(QUEUE_DEPTH)) ? QW'(s - (QW+1)'(QUEUE_DEPTH)) : s[QW-1:0];
  endfunction

  // Scan position: plans start at the slot, queries and commits at the head
  logic [QW:0] pos_sum;
  logic [QW-1:0] pos;
  always_comb begin
    if (func_r == FN_QUERY || func_r == FN_COMMIT) begin
      pos_sum = {1'b0, head_r} + (QW+1)'(cnt_r);
    end else begin
      pos_sum = {1'b0, idx_r} + (QW+1)'(cnt_r);
    end
    pos = (pos_sum >= (QW+1)'(QUEUE_DEPTH)) ? QW'(pos_sum - (QW+1)'(QUEUE_DEPTH))
                                            : pos_sum[QW-1:0];
  end

  // Shared compare unit: one entry per cycle
  wire e_active = !empty && (qdist(pos, head_r) < qdist(tail_r, head_r));
  wire [TW-1:0] e_tag = tag_mem[pos];
  wire addr_eq = (addr_mem[pos] == addr_r);
  wire [TW-1:0] sage = e_tag - rhead_r;
  wire [TW-1:0] lage = tag_r - rhead_r;
  wire younger = qdist(pos, idx_r) < qdist(tail_r, idx_r);
  wire last = (cnt_r == CW'(QUEUE_DEPTH - 1));
  wire plan_step = e_active && younger && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (acc && in_func == FN_PUSH && !full) begin
      tag_mem[tail_r]   <= in_rob_tag;
      bytes_mem[tail_r] <= in_byte_count;
      addr_mem[tail_r]  <= '0;
      data_mem[tail_r]  <= '0;
    end
    if (acc && in_func == FN_WADDR && slot_ok) begin
      addr_mem[slot_i] <= in_mem_address;
    end
    if (acc && in_func == FN_WDATA && slot_ok) begin
      data_mem[slot_i] <= in_store_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
      addr_known_r <= '0;
      data_known_r <= '0;
      committed_r <= '0;
    end else begin
      // Drop the result once taken
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            func_r <= in_func;
            tag_r <= in_rob_tag;
            rhead_r <= in_rob_head;
            addr_r <= (in_func == FN_WDATA) ? addr_mem[slot_i] : in_mem_address;
            idx_r <= slot_i;
            cnt_r <= '0;
            status_r <= (in_func == FN_PUSH && full) ? ST_FULL :
                        (in_func == FN_POP && empty) ? ST_EMPTY : ST_OK;
            plan_valid_r <= 1'b0;
            fsame_r <= 1'b0; funk_r <= 1'b0; fwd_r <= 1'b0;
            blocked_r <= 1'b0; reached_r <= 1'b0; val_r <= '0;
            own_tag_r <= tag_mem[slot_i];
            stag_r <= tag_mem[slot_i];
            utag_r <= tag_mem[slot_i];
            own_data_r <= (in_func == FN_WDATA) ? in_store_data : data_mem[slot_i];
            state_r <= scan_req ? S_SCAN : S_DONE;
            case (in_func)
              FN_PUSH: begin
                if (!full) begin
                  addr_known_r[tail_r] <= 1'b0;
                  data_known_r[tail_r] <= 1'b0;
                  committed_r[tail_r] <= 1'b0;
                  tail_r <= tail_inc;
                end
              end
              FN_WADDR: begin
                if (slot_ok) begin
                  addr_known_r[slot_i] <= 1'b1;
                end
              end
              FN_WDATA: begin
                if (slot_ok) begin
                  data_known_r[slot_i] <= 1'b1;
                end
              end
              FN_POP: begin
                if (!empty) begin
                  head_r <= head_inc;
                end
              end
              FN_FLUSH:  tail_r <= in_tail_snapshot[QW-1:0];
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // Advance one entry through the compare unit
          case (func_r)
            FN_COMMIT: begin
              if (e_active && e_tag == tag_r) begin
                committed_r[pos] <= 1'b1;
              end
            end
            FN_QUERY: begin
              if (e_active) begin
                if (!committed_r[pos] && sage < lage && addr_known_r[pos] && addr_eq) begin
                  blocked_r <= 1'b1;
                end
                if (!(reached_r || (!committed_r[pos] && sage > lage))) begin
                  if (!addr_known_r[pos]) begin
                    fwd_r <= 1'b0;
                  end else if (addr_eq) begin
                    fwd_r <= data_known_r[pos];
                    if (data_known_r[pos]) begin
                      val_r <= data_mem[pos];
                    end
                  end
                end else begin
                  reached_r <= 1'b1;
                end
              end
            end
            default: begin
              plan_valid_r <= 1'b1;
              if (plan_step) begin
                if (addr_known_r[pos] && addr_eq && !fsame_r) begin
                  fsame_r <= 1'b1;
                  stag_r <= e_tag;
                end else if (!addr_known_r[pos] && !funk_r) begin
                  funk_r <= 1'b1;
                  utag_r <= e_tag;
                end
              end
            end
          endcase
          cnt_r <= cnt_r + 1'b1;
          if (last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Hand the result to the output register
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result fields; unused ones read as zero
  wire is_q = (func_r == FN_QUERY);
  assign out_status         = status_r;
  assign out_forward_valid  = is_q && fwd_r;
  assign out_forward_value  = (is_q && fwd_r) ? val_r : '0;
  assign out_may_dispatch   = is_q && !blocked_r;
  assign out_plan_valid     = plan_valid_r;
  assign out_plan_store_tag = plan_valid_r ? own_tag_r : '0;
  assign out_plan_address   = plan_valid_r ? addr_r : '0;
  assign out_plan_value     = plan_valid_r ? own_data_r : '0;
  assign out_found_same     = plan_valid_r && fsame_r;
  assign out_same_tag       = plan_valid_r ? stag_r : '0;
  assign out_found_unknown  = plan_valid_r && funk_r;
  assign out_unknown_tag    = plan_valid_r ? utag_r : '0;

  `SQF_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ready, "request accepted while busy")
  `SQF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r, "result dropped while stalled")
  `SQF_ASSERT_NXT(a_done_out, clk, rst_n, state_r == S_DONE, out_valid_r, "result not presented")
  `SQF_ASSERT_IMP(a_status_plan, clk, rst_n, out_valid_r && plan_valid_r, status_r == ST_OK, "plan with error status")
  `SQF_ASSERT_NXT(a_push_bytes, clk, rst_n, acc && in_func == FN_PUSH && !full, bytes_mem[$past(tail_r)] == $past(in_byte_count), "store width not recorded")
endmodule
